### rtl/alte_pkg.sv
// ----------------------------------------------------------------------------
// alte_pkg
// Shared types and constants of the account ledger transfer engine.
// ----------------------------------------------------------------------------
package alte_pkg;

  localparam int unsigned LEDGER_ENTRIES = 1024;
  localparam int unsigned IDX_W  = (LEDGER_ENTRIES > 1) ? $clog2(LEDGER_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(LEDGER_ENTRIES + 1);
  localparam int unsigned KEY_W  = 160;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned AMT_W  = 62;
  localparam int unsigned IN_TDATA_W  = 512;
  localparam int unsigned OUT_TDATA_W = 200;

  localparam logic [1:0] ST_COINBASE = 2'd0;
  localparam logic [1:0] ST_APPLIED  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  typedef struct packed {
    logic             src_hit;
    logic [IDX_W-1:0] src_idx;
    logic             dst_hit;
    logic [IDX_W-1:0] dst_idx;
  } alte_scan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDS,
    S_RDD,
    S_CAPD,
    S_CALC,
    S_WRS,
    S_WRD,
    S_OUT
  } alte_state_e;

endpackage

### rtl/account_ledger_transfer_engine.sv
// ----------------------------------------------------------------------------
// account_ledger_transfer_engine
// Account table with key search, balance and nonce update per transaction.
// ----------------------------------------------------------------------------
// Flow: each input beat runs the linear key scan over the key RAM, one entry
//   per cycle, then S_RDS, S_RDD, S_CAPD, S_CALC, S_WRS, S_WRD and S_OUT to the
//   result beat, waiting in S_OUT while the previous result beat is held. A new
//   transaction is taken only in S_IDLE, after the last one is done.
// Reset: clears the entry count and control; table RAMs are not cleared.
module account_ledger_transfer_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // src_addr_hi, src_addr_mid, src_addr_lo, dst_addr_hi, dst_addr_mid,
  // dst_addr_lo, transfer_value, tx_fee, tx_nonce, zero fill
  input  logic [alte_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // is_coinbase
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // table_full, nonce_low, src_balance, dst_balance, src_next_nonce, zero fill
  output logic [alte_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                          m_axis_tuser
);
  import alte_pkg::*;

  alte_state_e state_q, state_d;

  logic              cb_q;
  logic [KEY_W-1:0]  skey_q, dkey_q;
  logic [AMT_W-1:0]  val_q, fee_q;
  logic [WORD_W-1:0] nonce_q;
  logic [CNT_W-1:0]  used_q;

  logic [WORD_W-1:0] sbal_q, snon_q, dbal_q;

  logic              s_we_q, s_new_q, d_we_q, d_new_q;
  logic [IDX_W-1:0]  s_idx_q, d_idx_q;
  logic [WORD_W-1:0] s_bal_q, s_non_q, d_bal_q;
  logic [1:0]        r_status_q;
  logic              r_full_q, r_nlow_q;
  logic [WORD_W-1:0] r_sbal_q, r_dbal_q, r_snon_q;

  logic              s_we_d, s_new_d, d_we_d, d_new_d;
  logic [IDX_W-1:0]  s_idx_d, d_idx_d;
  logic [WORD_W-1:0] s_bal_d, s_non_d, d_bal_d;
  logic [1:0]        r_status_d;
  logic              r_full_d, r_nlow_d;
  logic [WORD_W-1:0] r_sbal_d, r_dbal_d, r_snon_d;
  logic [CNT_W-1:0]  used_d;

  logic              m_valid_q;
  logic [1:0]        m_status_q;
  logic              m_full_q, m_nlow_q;
  logic [WORD_W-1:0] m_sbal_q, m_dbal_q, m_snon_q;

  logic              in_beat, scan_start, scan_done;
  alte_scan_t        scan_res;
  logic [IDX_W-1:0]  key_raddr, ent_raddr, waddr;
  logic [KEY_W-1:0]  key_rdata, key_wdata;
  logic [WORD_W-1:0] bal_rdata, non_rdata, bal_wdata, non_wdata;
  logic              key_we, bal_we, non_we;

  alte_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .used_i      (used_q),
    .src_key_i   (skey_q),
    .dst_key_i   (dkey_q),
    .key_rdata_i (key_rdata),
    .key_raddr_o (key_raddr),
    .done_o      (scan_done),
    .res_o       (scan_res)
  );

  alte_ram #(.Width(KEY_W), .Depth(LEDGER_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  alte_ram #(.Width(WORD_W), .Depth(LEDGER_ENTRIES)) u_bal_ram (
    .clk_i   (clk_i),
    .we_i    (bal_we),
    .waddr_i (waddr),
    .wdata_i (bal_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (bal_rdata)
  );

  alte_ram #(.Width(WORD_W), .Depth(LEDGER_ENTRIES)) u_non_ram (
    .clk_i   (clk_i),
    .we_i    (non_we),
    .waddr_i (waddr),
    .wdata_i (non_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (non_rdata)
  );

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_beat) state_d = S_SCAN;
      S_SCAN: if (scan_done) state_d = S_RDS;
      S_RDS:  state_d = S_RDD;
      S_RDD:  state_d = S_CAPD;
      S_CAPD: state_d = S_CALC;
      S_CALC: state_d = S_WRS;
      S_WRS:  state_d = S_WRD;
      S_WRD:  state_d = S_OUT;
      S_OUT:  if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    scan_start    = 1'b0;
    ent_raddr     = scan_res.dst_idx;
    key_we        = 1'b0;
    bal_we        = 1'b0;
    non_we        = 1'b0;
    waddr         = s_idx_q;
    key_wdata     = skey_q;
    bal_wdata     = s_bal_q;
    non_wdata     = s_non_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        scan_start    = in_beat;
      end
      S_RDS: ent_raddr = scan_res.src_idx;
      S_WRS: begin
        key_we = s_new_q;
        bal_we = s_we_q;
        non_we = s_we_q;
      end
      S_WRD: begin
        waddr     = d_idx_q;
        key_wdata = dkey_q;
        bal_wdata = d_bal_q;
        non_wdata = '0;
        key_we    = d_new_q;
        bal_we    = d_we_q;
        non_we    = d_new_q;
      end
      default: ;
    endcase
  end

  // transaction arithmetic
  always_comb begin
    logic [WORD_W-1:0] sb, sn, db, nxt;
    logic [AMT_W:0]    req;
    logic [WORD_W:0]   sum;
    logic [CNT_W-1:0]  used_mid;
    logic              same;
    sb       = scan_res.src_hit ? sbal_q : '0;
    sn       = scan_res.src_hit ? snon_q : '0;
    db       = scan_res.dst_hit ? dbal_q : '0;
    req      = {1'b0, val_q} + {1'b0, fee_q};
    nxt      = (nonce_q == '1) ? nonce_q : nonce_q + WORD_W'(1);
    same     = (skey_q == dkey_q);
    used_mid = used_q;
    sum      = '0;
    s_we_d   = 1'b0;
    s_new_d  = 1'b0;
    d_we_d   = 1'b0;
    d_new_d  = 1'b0;
    s_idx_d  = scan_res.src_idx;
    d_idx_d  = scan_res.dst_idx;
    s_bal_d  = sb - WORD_W'(req);
    s_non_d  = (nxt > sn) ? nxt : sn;
    d_bal_d  = db;
    r_full_d = 1'b0;
    r_nlow_d = 1'b0;
    r_sbal_d = '0;
    r_dbal_d = '0;
    r_snon_d = '0;
    used_d   = used_q;
    if (cb_q) begin
      r_status_d = ST_COINBASE;
      sum        = {1'b0, db} + (WORD_W + 1)'(val_q);
      d_bal_d    = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
      if (scan_res.dst_hit) begin
        d_we_d = 1'b1;
      end else if (used_q < CNT_W'(LEDGER_ENTRIES)) begin
        d_we_d  = 1'b1;
        d_new_d = 1'b1;
        d_idx_d = used_q[IDX_W-1:0];
        used_d  = used_q + CNT_W'(1);
      end else begin
        r_full_d = 1'b1;
      end
      r_dbal_d = d_we_d ? d_bal_d : '0;
    end else begin
      r_nlow_d = (nonce_q < sn);
      if (sb < WORD_W'(req)) begin
        r_status_d = ST_REJECTED;
        r_sbal_d   = sb;
        r_dbal_d   = db;
        r_snon_d   = sn;
      end else begin
        r_status_d = ST_APPLIED;
        if (scan_res.src_hit) begin
          s_we_d = 1'b1;
        end else if (used_q < CNT_W'(LEDGER_ENTRIES)) begin
          s_we_d   = 1'b1;
          s_new_d  = 1'b1;
          s_idx_d  = used_q[IDX_W-1:0];
          used_mid = used_q + CNT_W'(1);
        end else begin
          r_full_d = 1'b1;
        end
        used_d = used_mid;
        if (same) begin
          sum     = {1'b0, s_bal_d} + (WORD_W + 1)'(val_q);
          d_bal_d = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
          d_idx_d = s_idx_d;
          d_we_d  = s_we_d;
        end else begin
          sum     = {1'b0, db} + (WORD_W + 1)'(val_q);
          d_bal_d = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
          if (scan_res.dst_hit) begin
            d_we_d = 1'b1;
          end else if (used_mid < CNT_W'(LEDGER_ENTRIES)) begin
            d_we_d  = 1'b1;
            d_new_d = 1'b1;
            d_idx_d = used_mid[IDX_W-1:0];
            used_d  = used_mid + CNT_W'(1);
          end else begin
            r_full_d = 1'b1;
          end
        end
        r_sbal_d = s_we_d ? (same ? d_bal_d : s_bal_d) : '0;
        r_snon_d = s_we_d ? s_non_d : '0;
        r_dbal_d = d_we_d ? d_bal_d : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CALC) begin
        used_q <= used_d;
      end
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cb_q    <= s_axis_tuser;
      skey_q  <= s_axis_tdata[159:0];
      dkey_q  <= s_axis_tdata[319:160];
      val_q   <= s_axis_tdata[381:320];
      fee_q   <= s_axis_tdata[443:382];
      nonce_q <= s_axis_tdata[507:444];
    end
    if (state_q == S_RDD) begin
      sbal_q <= bal_rdata;
      snon_q <= non_rdata;
    end
    if (state_q == S_CAPD) begin
      dbal_q <= bal_rdata;
    end
    if (state_q == S_CALC) begin
      s_we_q     <= s_we_d;
      s_new_q    <= s_new_d;
      d_we_q     <= d_we_d;
      d_new_q    <= d_new_d;
      s_idx_q    <= s_idx_d;
      d_idx_q    <= d_idx_d;
      s_bal_q    <= s_bal_d;
      s_non_q    <= s_non_d;
      d_bal_q    <= d_bal_d;
      r_status_q <= r_status_d;
      r_full_q   <= r_full_d;
      r_nlow_q   <= r_nlow_d;
      r_sbal_q   <= r_sbal_d;
      r_dbal_q   <= r_dbal_d;
      r_snon_q   <= r_snon_d;
    end
    if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
      m_status_q <= r_status_q;
      m_full_q   <= r_full_q;
      m_nlow_q   <= r_nlow_q;
      m_sbal_q   <= r_sbal_q;
      m_dbal_q   <= r_dbal_q;
      m_snon_q   <= r_snon_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {6'd0, m_snon_q, m_dbal_q, m_sbal_q, m_nlow_q, m_full_q};

endmodule

### rtl/alte_ram.sv
// ----------------------------------------------------------------------------
// alte_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alte_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/alte_scan.sv
// ----------------------------------------------------------------------------
// alte_scan
// Linear key search: walk the used entries, match source and destination.
// ----------------------------------------------------------------------------
module alte_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alte_pkg::CNT_W-1:0]  used_i,
  input  logic [alte_pkg::KEY_W-1:0]  src_key_i,
  input  logic [alte_pkg::KEY_W-1:0]  dst_key_i,
  input  logic [alte_pkg::KEY_W-1:0]  key_rdata_i,
  output logic [alte_pkg::IDX_W-1:0]  key_raddr_o,
  output logic                        done_o,
  output alte_pkg::alte_scan_t        res_o
);
  import alte_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] cidx_q, cidx_d;
  alte_scan_t       res_q, res_d;

  assign key_raddr_o = cnt_q[IDX_W-1:0];
  assign res_o       = res_q;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rv_d   = 1'b0;
    cidx_d = cidx_q;
    res_d  = res_q;
    done_o = 1'b0;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      res_d  = '0;
    end else if (busy_q) begin
      if (rv_q) begin
        if (!res_q.src_hit && key_rdata_i == src_key_i) begin
          res_d.src_hit = 1'b1;
          res_d.src_idx = cidx_q;
        end
        if (!res_q.dst_hit && key_rdata_i == dst_key_i) begin
          res_d.dst_hit = 1'b1;
          res_d.dst_idx = cidx_q;
        end
      end
      if (cnt_q < used_i) begin
        rv_d   = 1'b1;
        cidx_d = cnt_q[IDX_W-1:0];
        cnt_d  = cnt_q + CNT_W'(1);
      end else if (!rv_q) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      rv_q   <= 1'b0;
      cidx_q <= '0;
      res_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      rv_q   <= rv_d;
      cidx_q <= cidx_d;
      res_q  <= res_d;
    end
  end

endmodule
